// ----- sv/wdsc_pkg.sv -----
// Shared types and constants of the wheel distance/speed controller.
// No dependencies; used by wdsc_ctrl, wdsc_dp and the top level.
package wdsc_pkg;

  localparam int PULSE_COUNT_WIDTH = 32;
  typedef logic [PULSE_COUNT_WIDTH-1:0] pulse_cnt_t;
  localparam pulse_cnt_t PULSE_MAX = '1;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P          = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I_DT       = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D_OVER_DT  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_PER_PULSE = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PULSES_PER_CM   = 3'd4;

  localparam logic [15:0] SPEED_PER_PULSE_RST = 16'd256;
  localparam logic [15:0] PULSES_PER_CM_RST   = 16'd256;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PULSE = 2'd1;
  localparam logic [1:0] OP_MOVE  = 2'd2;
  localparam logic [1:0] OP_WALK  = 2'd3;

  // motion modes
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_MOVING   = 2'd1;
  localparam logic [1:0] MODE_WALKING  = 2'd2;
  localparam logic [1:0] MODE_STOPPING = 2'd3;

  // drive modes
  localparam logic [1:0] DRV_FWD   = 2'd0;
  localparam logic [1:0] DRV_BWD   = 2'd1;
  localparam logic [1:0] DRV_BRAKE = 2'd2;
  localparam logic [1:0] DRV_COAST = 2'd3;

  localparam logic [15:0] INTEG_MAX = 16'hFF00;  // 255.0 in Q8.8
  localparam logic [7:0]  DUTY_MAX  = 8'd255;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic pulse;
    logic mul_target;
    logic start_move;
    logic start_walk;
    logic stop;
    logic mul_speed;
    logic calc_err;
    logic mul_i;
    logic integ;
    logic dterm;
    logic finish;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic active;   // moving or walking
    logic reached;  // moving and target count met
  } dp_stat_t;

endpackage

// ----- sv/wdsc_ctrl.sv -----
// Sequencer of the wheel controller: decodes an accepted item and steps
// the datapath through it. Depends on wdsc_pkg.
module wdsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  output logic              out_valid,
  input  logic              out_ready,
  input  wdsc_pkg::dp_stat_t stat,
  output wdsc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_PULSE      = 13'b0000000000010,
    S_MUL_TARGET = 13'b0000000000100,
    S_START_MOVE = 13'b0000000001000,
    S_START_WALK = 13'b0000000010000,
    S_STOP       = 13'b0000000100000,
    S_SPEED      = 13'b0000001000000,
    S_ERR        = 13'b0000010000000,
    S_MUL_I      = 13'b0000100000000,
    S_INTEG      = 13'b0001000000000,
    S_DTERM      = 13'b0010000000000,
    S_FINISH     = 13'b0100000000000,
    S_DONE       = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            wdsc_pkg::OP_PULSE: state_nxt = S_PULSE;
            wdsc_pkg::OP_MOVE:  state_nxt = S_MUL_TARGET;
            wdsc_pkg::OP_WALK:  state_nxt = S_START_WALK;
            default: begin
              if (stat.reached)     state_nxt = S_STOP;
              else if (stat.active) state_nxt = S_SPEED;
              else                  state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_PULSE:      state_nxt = S_DONE;
      S_MUL_TARGET: state_nxt = S_START_MOVE;
      S_START_MOVE: state_nxt = S_DONE;
      S_START_WALK: state_nxt = S_DONE;
      S_STOP:       state_nxt = S_DONE;
      S_SPEED:      state_nxt = S_ERR;
      S_ERR:        state_nxt = S_MUL_I;
      S_MUL_I:      state_nxt = S_INTEG;
      S_INTEG:      state_nxt = S_DTERM;
      S_DTERM:      state_nxt = S_FINISH;
      S_FINISH:     state_nxt = S_DONE;
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (load_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_comb begin
    cmd            = '0;
    cmd.load_in    = accept;
    cmd.pulse      = (state_r == S_PULSE);
    cmd.mul_target = (state_r == S_MUL_TARGET);
    cmd.start_move = (state_r == S_START_MOVE);
    cmd.start_walk = (state_r == S_START_WALK);
    cmd.stop       = (state_r == S_STOP);
    cmd.mul_speed  = (state_r == S_SPEED);
    cmd.calc_err   = (state_r == S_ERR);
    cmd.mul_i      = (state_r == S_MUL_I);
    cmd.integ      = (state_r == S_INTEG);
    cmd.dterm      = (state_r == S_DTERM);
    cmd.finish     = (state_r == S_FINISH);
    cmd.load_out   = load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("item accepted while another is in progress");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result loaded without valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule

// ----- sv/wdsc_dp.sv -----
// Datapath of the wheel controller: configuration, motion state, shared
// multiplier, PID arithmetic and result register. Depends on wdsc_pkg.
module wdsc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wdsc_pkg::dp_cmd_t                    cmd,
  output wdsc_pkg::dp_stat_t                   stat,
  input  logic                                 cfg_we,
  input  logic [wdsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [wdsc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
  input  logic [15:0]                          in_distance_cm,
  input  logic [15:0]                          in_speed_setpoint,
  input  logic                                 in_with_brake,
  input  logic                                 in_drive_forward,
  input  logic                                 in_direction_level,
  output logic [1:0]                           out_drive_mode,
  output logic [7:0]                           out_drive_duty,
  output logic [1:0]                           out_motion_state,
  output logic [15:0]                          out_measured_speed,
  output logic [31:0]                          out_travelled_pulses,
  output logic                                 out_sensed_forward
);

  // configuration
  logic [15:0] gain_p_r, gain_i_r, gain_d_r, spp_r, ppc_r;

  // architectural state
  logic [1:0]              mode_r, mode_nxt;
  logic [15:0]             tick_pulses_r, tick_pulses_nxt;
  wdsc_pkg::pulse_cnt_t    move_pulses_r, move_pulses_nxt;
  wdsc_pkg::pulse_cnt_t    target_r, target_nxt;
  logic [15:0]             target_speed_r, target_speed_nxt;
  logic [15:0]             cur_speed_r, cur_speed_nxt;
  logic [15:0]             integ_r, integ_nxt;
  logic signed [16:0]      prev_err_r, prev_err_nxt;
  logic                    brake_r, brake_nxt;
  logic                    fwd_r, fwd_nxt;
  logic                    last_dir_r, last_dir_nxt;
  logic [1:0]              drv_mode_r, drv_mode_nxt;
  logic [7:0]              duty_r, duty_nxt;

  // item latch and working registers
  logic [15:0]        dist_in_r, setp_in_r;
  logic               brake_in_r, fwd_in_r, dir_in_r;
  logic signed [34:0] prod_r;
  logic signed [35:0] sum_r;
  logic signed [16:0] err_r;

  // shared multiplier: 18-bit signed by 16-bit unsigned
  logic signed [17:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [34:0] mul_p;
  logic               mul_en;

  always_comb begin
    mul_a = {2'b00, tick_pulses_r};
    mul_b = spp_r;
    if (cmd.mul_target) begin
      mul_a = {2'b00, dist_in_r};
      mul_b = ppc_r;
    end else if (cmd.mul_i) begin
      mul_a = {err_r[16], err_r};
      mul_b = gain_i_r;
    end else if (cmd.integ) begin
      mul_a = {err_r[16], err_r};
      mul_b = gain_p_r;
    end else if (cmd.dterm) begin
      mul_a = {err_r[16], err_r} - {prev_err_r[16], prev_err_r};
      mul_b = gain_d_r;
    end
  end

  assign mul_p  = mul_a * $signed({1'b0, mul_b});
  assign mul_en = cmd.mul_target | cmd.mul_speed | cmd.mul_i | cmd.integ | cmd.dterm;

  // derived values
  logic [23:0]        prod_q;
  logic [31:0]        target_ext;
  logic [15:0]        speed_sat;
  logic signed [35:0] prod_ext;
  logic signed [35:0] integ_sum;
  logic [15:0]        integ_clamped;
  logic signed [35:0] sum_fin;
  logic [7:0]         duty_calc;

  assign prod_q     = prod_r[31:8];
  assign target_ext = {8'd0, prod_q};
  assign speed_sat  = (|prod_r[31:24]) ? 16'hFFFF : prod_r[23:8];
  assign prod_ext   = {prod_r[34], prod_r};
  assign integ_sum  = $signed({20'd0, integ_r}) + prod_ext;
  assign sum_fin    = sum_r + prod_ext;

  always_comb begin
    if (integ_sum[35])
      integ_clamped = '0;
    else if (integ_sum > $signed({20'd0, wdsc_pkg::INTEG_MAX}))
      integ_clamped = wdsc_pkg::INTEG_MAX;
    else
      integ_clamped = integ_sum[15:0];
  end

  always_comb begin
    if (sum_fin[35])         duty_calc = '0;
    else if (|sum_fin[34:16]) duty_calc = wdsc_pkg::DUTY_MAX;
    else                     duty_calc = sum_fin[15:8];
  end

  assign stat.active  = (mode_r == wdsc_pkg::MODE_MOVING) ||
                        (mode_r == wdsc_pkg::MODE_WALKING);
  assign stat.reached = (mode_r == wdsc_pkg::MODE_MOVING) && (move_pulses_r >= target_r);

  // state updates
  always_comb begin
    mode_nxt         = mode_r;
    tick_pulses_nxt  = tick_pulses_r;
    move_pulses_nxt  = move_pulses_r;
    target_nxt       = target_r;
    target_speed_nxt = target_speed_r;
    cur_speed_nxt    = cur_speed_r;
    integ_nxt        = integ_r;
    prev_err_nxt     = prev_err_r;
    brake_nxt        = brake_r;
    fwd_nxt          = fwd_r;
    last_dir_nxt     = last_dir_r;
    drv_mode_nxt     = drv_mode_r;
    duty_nxt         = duty_r;

    if (cmd.pulse) begin
      if (tick_pulses_r != 16'hFFFF)
        tick_pulses_nxt = tick_pulses_r + 16'd1;
      if (move_pulses_r != wdsc_pkg::PULSE_MAX)
        move_pulses_nxt = move_pulses_r + 1'b1;
      last_dir_nxt = dir_in_r;
    end

    if (cmd.start_move || cmd.start_walk) begin
      drv_mode_nxt     = wdsc_pkg::DRV_COAST;
      duty_nxt         = '0;
      fwd_nxt          = fwd_in_r;
      target_speed_nxt = setp_in_r;
      integ_nxt        = '0;
      prev_err_nxt     = '0;
      mode_nxt         = wdsc_pkg::MODE_WALKING;
    end

    if (cmd.start_move) begin
      brake_nxt       = brake_in_r;
      move_pulses_nxt = '0;
      if (target_ext > 32'(wdsc_pkg::PULSE_MAX))
        target_nxt = wdsc_pkg::PULSE_MAX;
      else
        target_nxt = target_ext[wdsc_pkg::PULSE_COUNT_WIDTH-1:0];
      mode_nxt = wdsc_pkg::MODE_MOVING;
    end

    if (cmd.stop) begin
      drv_mode_nxt = brake_r ? wdsc_pkg::DRV_BRAKE : wdsc_pkg::DRV_COAST;
      duty_nxt     = '0;
      mode_nxt     = wdsc_pkg::MODE_IDLE;
    end

    if (cmd.calc_err) begin
      cur_speed_nxt   = speed_sat;
      tick_pulses_nxt = '0;
    end

    if (cmd.integ)
      integ_nxt = integ_clamped;

    if (cmd.finish) begin
      prev_err_nxt = err_r;
      duty_nxt     = duty_calc;
      drv_mode_nxt = fwd_r ? wdsc_pkg::DRV_FWD : wdsc_pkg::DRV_BWD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r       <= '0;
      gain_i_r       <= '0;
      gain_d_r       <= '0;
      spp_r          <= wdsc_pkg::SPEED_PER_PULSE_RST;
      ppc_r          <= wdsc_pkg::PULSES_PER_CM_RST;
      mode_r         <= wdsc_pkg::MODE_IDLE;
      tick_pulses_r  <= '0;
      move_pulses_r  <= '0;
      target_r       <= '0;
      target_speed_r <= '0;
      cur_speed_r    <= '0;
      integ_r        <= '0;
      prev_err_r     <= '0;
      brake_r        <= 1'b0;
      fwd_r          <= 1'b0;
      last_dir_r     <= 1'b0;
      drv_mode_r     <= wdsc_pkg::DRV_COAST;
      duty_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wdsc_pkg::REG_GAIN_P:          gain_p_r <= cfg_wdata;
          wdsc_pkg::REG_GAIN_I_DT:       gain_i_r <= cfg_wdata;
          wdsc_pkg::REG_GAIN_D_OVER_DT:  gain_d_r <= cfg_wdata;
          wdsc_pkg::REG_SPEED_PER_PULSE: spp_r    <= cfg_wdata;
          wdsc_pkg::REG_PULSES_PER_CM:   ppc_r    <= cfg_wdata;
          default: ;
        endcase
      end
      mode_r         <= mode_nxt;
      tick_pulses_r  <= tick_pulses_nxt;
      move_pulses_r  <= move_pulses_nxt;
      target_r       <= target_nxt;
      target_speed_r <= target_speed_nxt;
      cur_speed_r    <= cur_speed_nxt;
      integ_r        <= integ_nxt;
      prev_err_r     <= prev_err_nxt;
      brake_r        <= brake_nxt;
      fwd_r          <= fwd_nxt;
      last_dir_r     <= last_dir_nxt;
      drv_mode_r     <= drv_mode_nxt;
      duty_r         <= duty_nxt;
    end
  end

  // payload and working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dist_in_r  <= in_distance_cm;
      setp_in_r  <= in_speed_setpoint;
      brake_in_r <= in_with_brake;
      fwd_in_r   <= in_drive_forward;
      dir_in_r   <= in_direction_level;
    end
    if (mul_en)
      prod_r <= mul_p;
    if (cmd.calc_err)
      err_r <= $signed({1'b0, target_speed_r}) - $signed({1'b0, speed_sat});
    if (cmd.integ)
      sum_r <= {20'd0, integ_clamped};
    else if (cmd.dterm)
      sum_r <= sum_r + prod_ext;
    if (cmd.load_out) begin
      out_drive_mode       <= drv_mode_r;
      out_drive_duty       <= duty_r;
      out_motion_state     <= mode_r;
      out_measured_speed   <= cur_speed_r;
      out_travelled_pulses <= 32'(move_pulses_r);
      out_sensed_forward   <= last_dir_r;
    end
  end

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    integ_r <= wdsc_pkg::INTEG_MAX)
    else $error("integral outside 0..255.0");

  a_idle_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (drv_mode_r == wdsc_pkg::DRV_BRAKE || drv_mode_r == wdsc_pkg::DRV_COAST)
      |-> duty_r == '0)
    else $error("duty set while braking or coasting");

endmodule

// ----- sv/wheel_distance_speed_controller_core.sv -----
// Steps from input transfer to out_valid: idle tick goes straight to DONE; pulse,
// walk, stop tick via PULSE, START_WALK, STOP; move via MUL_TARGET, START_MOVE; PID tick
// via SPEED, ERR, MUL_I, INTEG, DTERM, FINISH. One item at a time; a waiting result
// stalls the next in DONE. PID uses the one 18x17 multiplier for speed, I, P, D in turn.
// Reset (synchronous, rst_n low) clears the motion state, the drive registers to coast/0,
// gains to 0 and both scales to 1.0; no clearing pass.
// Top level of the wheel distance/speed controller: wdsc_ctrl sequences wdsc_dp.
// Depends on wdsc_pkg, wdsc_ctrl, wdsc_dp.
module wheel_distance_speed_controller_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [wdsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [wdsc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
  // item channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_operation,
  input  logic [15:0]                          in_distance_cm,
  input  logic [15:0]                          in_speed_setpoint,
  input  logic                                 in_with_brake,
  input  logic                                 in_drive_forward,
  input  logic                                 in_direction_level,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_drive_mode,
  output logic [7:0]                           out_drive_duty,
  output logic [1:0]                           out_motion_state,
  output logic [15:0]                          out_measured_speed,
  output logic [31:0]                          out_travelled_pulses,
  output logic                                 out_sensed_forward
);

  // Command and status between sequencer and datapath. The sequencer
  // decodes the operation at the input transfer, using the datapath's
  // status (moving/walking, target reached) to pick the tick path:
  // stop, full PID, or nothing. The result register sits in the
  // datapath and is loaded once the previous result transfer is done,
  // so a new item can be taken while a result still waits.
  wdsc_pkg::dp_cmd_t  cmd;
  wdsc_pkg::dp_stat_t stat;

  wdsc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Datapath: speed = pulses * scale, then err, I (clamped), P and D
  // products in successive cycles through one multiplier.
  wdsc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_distance_cm       (in_distance_cm),
    .in_speed_setpoint    (in_speed_setpoint),
    .in_with_brake        (in_with_brake),
    .in_drive_forward     (in_drive_forward),
    .in_direction_level   (in_direction_level),
    .out_drive_mode       (out_drive_mode),
    .out_drive_duty       (out_drive_duty),
    .out_motion_state     (out_motion_state),
    .out_measured_speed   (out_measured_speed),
    .out_travelled_pulses (out_travelled_pulses),
    .out_sensed_forward   (out_sensed_forward)
  );

endmodule

// ----- test/wheel_distance_speed_controller_core_tb.sv -----
// Self-checking testbench for wheel_distance_speed_controller_core: a directed table,
// then random motion sequences under several gain settings.
// Depends on wdsc_pkg and the core; results are checked against an in-bench wheel model.
module wheel_distance_speed_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 2_000_000;  // hang guard, several times the slowest run
  localparam int DRAIN_CYCLES = 20;         // longest item is the PID tick
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 112;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] distance_cm;
    logic [15:0] speed_setpoint;
    logic        with_brake;
    logic        drive_forward;
    logic        direction_level;
  } wheel_cmd_t;

  typedef struct packed {
    logic [1:0]  drive_mode;
    logic [7:0]  drive_duty;
    logic [1:0]  motion_state;
    logic [15:0] measured_speed;
    logic [31:0] travelled_pulses;
    logic        sensed_forward;
  } drive_result_t;

  // One directed row: the command, and a hand-worked result where it is obvious.
  typedef struct packed {
    wheel_cmd_t    cmd;
    logic          fixed;
    drive_result_t res;
  } directed_row_t;

  localparam int NUM_DIRECTED = 26;

  // Rows 0..9 run with reset scales and gain_p = 1.0, all other gains 0.
  localparam directed_row_t DIRECTED[NUM_DIRECTED] = '{
    // tick while idle, every unused field at its top: nothing moves
    '{'{wdsc_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{wdsc_pkg::DRV_COAST, 8'd0, wdsc_pkg::MODE_IDLE, 16'd0, 32'd0, 1'b0}},
    // pulses while idle still count and sample direction
    '{'{wdsc_pkg::OP_PULSE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{wdsc_pkg::DRV_COAST, 8'd0, wdsc_pkg::MODE_IDLE, 16'd0, 32'd1, 1'b1}},
    '{'{wdsc_pkg::OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{wdsc_pkg::DRV_COAST, 8'd0, wdsc_pkg::MODE_IDLE, 16'd0, 32'd2, 1'b0}},
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{wdsc_pkg::DRV_COAST, 8'd0, wdsc_pkg::MODE_IDLE, 16'd0, 32'd2, 1'b0}},
    // zero-distance move with brake: coasts, then the next tick brakes and idles
    '{'{wdsc_pkg::OP_MOVE, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{wdsc_pkg::DRV_COAST, 8'd0, wdsc_pkg::MODE_MOVING, 16'd0, 32'd0, 1'b0}},
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{wdsc_pkg::DRV_BRAKE, 8'd0, wdsc_pkg::MODE_IDLE, 16'd0, 32'd0, 1'b0}},
    // zero-distance move without brake ends in coast
    '{'{wdsc_pkg::OP_MOVE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{wdsc_pkg::DRV_COAST, 8'd0, wdsc_pkg::MODE_MOVING, 16'd0, 32'd0, 1'b0}},
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{wdsc_pkg::DRV_COAST, 8'd0, wdsc_pkg::MODE_IDLE, 16'd0, 32'd0, 1'b0}},
    // walk at full setpoint; distance and brake are ignored
    '{'{wdsc_pkg::OP_WALK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0}, 1'b1,
      '{wdsc_pkg::DRV_COAST, 8'd0, wdsc_pkg::MODE_WALKING, 16'd0, 32'd0, 1'b0}},
    // two pulses pending since reset give speed 2; P term alone saturates the duty
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{wdsc_pkg::DRV_FWD, wdsc_pkg::DUTY_MAX, wdsc_pkg::MODE_WALKING, 16'd2, 32'd0, 1'b0}},
    '{'{wdsc_pkg::OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{wdsc_pkg::OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{wdsc_pkg::OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    // walk backward at zero setpoint
    '{'{wdsc_pkg::OP_WALK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    // longest move: target far away, the tick runs the loop
    '{'{wdsc_pkg::OP_MOVE, 16'hFFFF, 16'd1234, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{wdsc_pkg::OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    // short move reaches its target and brakes
    '{'{wdsc_pkg::OP_MOVE, 16'd3, 16'd100, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{wdsc_pkg::OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{wdsc_pkg::OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{wdsc_pkg::OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{wdsc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{wdsc_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        cfg_we             = 1'b0;
  logic [wdsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [wdsc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation       = wdsc_pkg::OP_TICK;
  logic [15:0] in_distance_cm     = '0;
  logic [15:0] in_speed_setpoint  = '0;
  logic        in_with_brake      = 1'b0;
  logic        in_drive_forward   = 1'b0;
  logic        in_direction_level = 1'b0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [1:0]  out_drive_mode;
  logic [7:0]  out_drive_duty;
  logic [1:0]  out_motion_state;
  logic [15:0] out_measured_speed;
  logic [31:0] out_travelled_pulses;
  logic        out_sensed_forward;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wheel_distance_speed_controller_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_distance_cm       (in_distance_cm),
    .in_speed_setpoint    (in_speed_setpoint),
    .in_with_brake        (in_with_brake),
    .in_drive_forward     (in_drive_forward),
    .in_direction_level   (in_direction_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drive_mode       (out_drive_mode),
    .out_drive_duty       (out_drive_duty),
    .out_motion_state     (out_motion_state),
    .out_measured_speed   (out_measured_speed),
    .out_travelled_pulses (out_travelled_pulses),
    .out_sensed_forward   (out_sensed_forward)
  );

  // ---------------------------------------------------------------------------
  // Wheel model: register copies and controller state at the block's widths
  // ---------------------------------------------------------------------------
  logic [15:0]          gain_p_q, gain_i_q, gain_d_q, speed_scale_q, dist_scale_q;
  logic [1:0]           motion_q;
  logic [15:0]          tick_count_q;
  wdsc_pkg::pulse_cnt_t move_count_q, target_count_q;
  logic [15:0]          setpoint_q, speed_q, integ_q;
  logic signed [16:0]   last_err_q;
  logic                 brake_end_q, forward_q, dir_seen_q;
  logic [1:0]           drive_q;
  logic [7:0]           duty_q;

  drive_result_t pending_results[$];  // predicted results, oldest first
  int snd_idle_pct  = 0;               // chance per cycle that the sender holds off
  int rcv_stall_pct = 0;               // chance per cycle that the receiver stalls
  int items_sent    = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  task automatic reset_wheel_model();
    gain_p_q       = '0;
    gain_i_q       = '0;
    gain_d_q       = '0;
    speed_scale_q  = wdsc_pkg::SPEED_PER_PULSE_RST;
    dist_scale_q   = wdsc_pkg::PULSES_PER_CM_RST;
    motion_q       = wdsc_pkg::MODE_IDLE;
    tick_count_q   = '0;
    move_count_q   = '0;
    target_count_q = '0;
    setpoint_q     = '0;
    speed_q        = '0;
    integ_q        = '0;
    last_err_q     = '0;
    brake_end_q    = 1'b0;
    forward_q      = 1'b0;
    dir_seen_q     = 1'b0;
    drive_q        = wdsc_pkg::DRV_COAST;
    duty_q         = '0;
  endtask

  // Advance the wheel model by one command and return the result it shows.
  function automatic drive_result_t advance_wheel(wheel_cmd_t c);
    drive_result_t r;
    longint spd, err, integ, sum, duty, tgt;
    case (c.op)
      wdsc_pkg::OP_TICK: begin
        // a reached move stops within the same tick, so stopping never shows
        if (motion_q == wdsc_pkg::MODE_MOVING && move_count_q >= target_count_q)
          motion_q = wdsc_pkg::MODE_STOPPING;
        if (motion_q == wdsc_pkg::MODE_MOVING || motion_q == wdsc_pkg::MODE_WALKING) begin
          spd = (longint'(tick_count_q) * longint'(speed_scale_q)) >>> 8;
          speed_q = (spd > 65535) ? 16'hFFFF : spd[15:0];
          tick_count_q = '0;
          err   = longint'(setpoint_q) - longint'(speed_q);
          integ = longint'(integ_q) + err * longint'(gain_i_q);
          if (integ < 0) integ = 0;
          if (integ > longint'(wdsc_pkg::INTEG_MAX)) integ = longint'(wdsc_pkg::INTEG_MAX);
          integ_q = integ[15:0];
          sum = err * longint'(gain_p_q) + integ
              + (err - longint'(last_err_q)) * longint'(gain_d_q);
          last_err_q = err[16:0];
          duty = sum >>> 8;
          if (sum < 0) duty_q = '0;
          else duty_q = (duty > longint'(wdsc_pkg::DUTY_MAX)) ? wdsc_pkg::DUTY_MAX : duty[7:0];
          drive_q = forward_q ? wdsc_pkg::DRV_FWD : wdsc_pkg::DRV_BWD;
        end else if (motion_q == wdsc_pkg::MODE_STOPPING) begin
          drive_q  = brake_end_q ? wdsc_pkg::DRV_BRAKE : wdsc_pkg::DRV_COAST;
          duty_q   = '0;
          motion_q = wdsc_pkg::MODE_IDLE;
        end
      end
      wdsc_pkg::OP_PULSE: begin
        if (tick_count_q != 16'hFFFF) tick_count_q = tick_count_q + 16'd1;
        if (move_count_q != wdsc_pkg::PULSE_MAX) move_count_q = move_count_q + 1'b1;
        dir_seen_q = c.direction_level;
      end
      default: begin
        // move and walk both coast until the next tick and restart the loop
        drive_q    = wdsc_pkg::DRV_COAST;
        duty_q     = '0;
        forward_q  = c.drive_forward;
        setpoint_q = c.speed_setpoint;
        integ_q    = '0;
        last_err_q = '0;
        if (c.op == wdsc_pkg::OP_MOVE) begin
          tgt = (longint'(c.distance_cm) * longint'(dist_scale_q)) >>> 8;
          target_count_q = (tgt > longint'(wdsc_pkg::PULSE_MAX)) ?
                           wdsc_pkg::PULSE_MAX : wdsc_pkg::pulse_cnt_t'(tgt);
          brake_end_q  = c.with_brake;
          move_count_q = '0;
          motion_q     = wdsc_pkg::MODE_MOVING;
        end else begin
          motion_q = wdsc_pkg::MODE_WALKING;
        end
      end
    endcase
    r.drive_mode       = drive_q;
    r.drive_duty       = duty_q;
    r.motion_state     = motion_q;
    r.measured_speed   = speed_q;
    r.travelled_pulses = 32'(move_count_q);
    r.sensed_forward   = dir_seen_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration writes; only issued with nothing in flight
  // ---------------------------------------------------------------------------
  // Leaves cfg_we high so back-to-back writes never lower and raise it in one step.
  task automatic put_reg(logic [wdsc_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      wdsc_pkg::REG_GAIN_P:          gain_p_q      = val;
      wdsc_pkg::REG_GAIN_I_DT:       gain_i_q      = val;
      wdsc_pkg::REG_GAIN_D_OVER_DT:  gain_d_q      = val;
      wdsc_pkg::REG_SPEED_PER_PULSE: speed_scale_q = val;
      wdsc_pkg::REG_PULSES_PER_CM:   dist_scale_q  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_settings(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                                logic [15:0] spp, logic [15:0] ppc);
    put_reg(wdsc_pkg::REG_GAIN_P, gp);
    put_reg(wdsc_pkg::REG_GAIN_I_DT, gi);
    put_reg(wdsc_pkg::REG_GAIN_D_OVER_DT, gd);
    put_reg(wdsc_pkg::REG_SPEED_PER_PULSE, spp);
    put_reg(wdsc_pkg::REG_PULSES_PER_CM, ppc);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Called at a clock step; returns at the step of the accepting edge with
  // in_valid still high, so the next call decides whether it drops.
  task automatic send_cmd(wheel_cmd_t c, logic fixed, drive_result_t fixed_res);
    drive_result_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= c.op;
    in_distance_cm     <= c.distance_cm;
    in_speed_setpoint  <= c.speed_setpoint;
    in_with_brake      <= c.with_brake;
    in_drive_forward   <= c.drive_forward;
    in_direction_level <= c.direction_level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer taken at this edge
    predicted = advance_wheel(c);
    pending_results.push_back(fixed ? fixed_res : predicted);
    items_sent++;
  endtask

  // Unused fields carry random junk so every input bit toggles.
  function automatic wheel_cmd_t noisy_cmd(logic [1:0] op);
    wheel_cmd_t c;
    c.op              = op;
    c.distance_cm     = 16'($urandom);
    c.speed_setpoint  = 16'($urandom);
    c.with_brake      = 1'($urandom);
    c.drive_forward   = 1'($urandom);
    c.direction_level = 1'($urandom);
    return c;
  endfunction

  // Drop valid and wait until every predicted result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // A move or walk followed by rounds of encoder pulses, each closed by a tick.
  // Rounds stop once stop_at items have been sent, so a phase keeps its budget.
  task automatic run_episode(int stop_at);
    wheel_cmd_t c;
    int rounds, pulses;
    c = noisy_cmd(($urandom_range(99) < 60) ? wdsc_pkg::OP_MOVE : wdsc_pkg::OP_WALK);
    // short moves so most of them finish within the episode
    if ($urandom_range(99) < 75) c.distance_cm = 16'($urandom_range(0, 24));
    case ($urandom_range(3))
      0, 1: c.speed_setpoint = 16'($urandom_range(0, 64));
      2:    c.speed_setpoint = 16'($urandom_range(0, 3000));
      default: ;  // keep the full-range setpoint
    endcase
    send_cmd(c, 1'b0, '0);
    rounds = $urandom_range(1, 8);
    repeat (rounds) begin
      if (items_sent < stop_at) begin
        // now and then a long run of pulses to push the measured speed to its limit
        pulses = ($urandom_range(99) < 5) ? $urandom_range(200, 400) : $urandom_range(0, 12);
        if (pulses > stop_at - items_sent) pulses = stop_at - items_sent;
        repeat (pulses) send_cmd(noisy_cmd(wdsc_pkg::OP_PULSE), 1'b0, '0);
        send_cmd(noisy_cmd(wdsc_pkg::OP_TICK), 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  task automatic note_mismatch(string field, longint unsigned exp_v, longint unsigned got_v);
    $error("%s: expected %0d, got %0d", field, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, drive_mode", 0, out_drive_mode);
      end else begin
        want = pending_results.pop_front();
        if (out_drive_mode !== want.drive_mode)
          note_mismatch("drive_mode", want.drive_mode, out_drive_mode);
        if (out_drive_duty !== want.drive_duty)
          note_mismatch("drive_duty", want.drive_duty, out_drive_duty);
        if (out_motion_state !== want.motion_state)
          note_mismatch("motion_state", want.motion_state, out_motion_state);
        if (out_measured_speed !== want.measured_speed)
          note_mismatch("measured_speed", want.measured_speed, out_measured_speed);
        if (out_travelled_pulses !== want.travelled_pulses)
          note_mismatch("travelled_pulses", want.travelled_pulses, out_travelled_pulses);
        if (out_sensed_forward !== want.sensed_forward)
          note_mismatch("sensed_forward", want.sensed_forward, out_sensed_forward);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    int idle_mode;
    reset_wheel_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset scales, P gain of 1.0 so the first loop tick saturates.
    put_reg(wdsc_pkg::REG_GAIN_P, 16'h0100);
    cfg_we <= 1'b0;
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_cmd(DIRECTED[i].cmd, DIRECTED[i].fixed, DIRECTED[i].res);

    // Random phases, each with its own settings and handshake pressure.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: write_settings(16'h0100, 16'h0020, 16'h0040, 16'd256, 16'd256);
        1: write_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        2: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        7: write_settings(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom_range(16, 2048)), 16'($urandom_range(16, 1024)));
        default:
          write_settings(16'($urandom_range(0, 16'h0600)), 16'($urandom_range(0, 16'h0600)),
                         16'($urandom_range(0, 16'h0600)), 16'($urandom_range(16, 2048)),
                         16'($urandom_range(16, 1024)));
      endcase
      idle_mode     = ph % 4;
      snd_idle_pct  = (idle_mode == 1) ? 53 : (idle_mode == 3) ? 34 : 0;
      rcv_stall_pct = (idle_mode == 2) ? 53 : (idle_mode == 3) ? 34 : 0;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        // mostly well-formed motion, some stray commands in between
        if ($urandom_range(99) < 85) run_episode(target);
        else send_cmd(noisy_cmd(2'($urandom)), 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
